### rtl/tile_index_decompose_4d_core_macros.svh
// Assertion helpers shared by the tile index decomposer.
`ifndef TILE_INDEX_DECOMPOSE_4D_CORE_MACROS_SVH
`define TILE_INDEX_DECOMPOSE_4D_CORE_MACROS_SVH

// Condition in the same cycle implies the consequence in the same cycle.
`define TIDC_ASSERT_IMPL(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("tile index decomposer: same-cycle check failed");

// Condition in one cycle implies the consequence in the next cycle.
`define TIDC_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("tile index decomposer: next-cycle check failed");

`endif

### rtl/tidc_pkg.sv
package tidc_pkg;

   localparam int COUNT_BITS = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_CAP = 32'h8000_0000;

   localparam int NUM_DIMS = 4;
   localparam int DIM_I = 0;
   localparam int DIM_J = 1;
   localparam int DIM_K = 2;
   localparam int DIM_L = 3;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXTENT_I = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXTENT_J = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXTENT_K = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXTENT_L = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_I   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_J   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_K   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_L   = 3'd7;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [63:0] wide_product_type;

   // Products of tile counts saturate at two to the thirty-first.
   function automatic count_type sat_count(input wide_product_type p);
      count_type r;
      if (p > wide_product_type'(COUNT_CAP)) begin
         r = COUNT_CAP;
      end else begin
         r = p[COUNT_BITS-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/tidc_if.sv
interface tidc_req_if #(parameter int INDEX_BITS = 31);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] tile_number;

   modport source (output valid, output tile_number, input ready);
   modport sink (input valid, input tile_number, output ready);
endinterface

interface tidc_rsp_if #(parameter int EXTENT_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [EXTENT_BITS-1:0] offset_i;
   logic [EXTENT_BITS-1:0] offset_j;
   logic [EXTENT_BITS-1:0] offset_k;
   logic [EXTENT_BITS-1:0] offset_l;
   logic [EXTENT_BITS-1:0] size_i;
   logic [EXTENT_BITS-1:0] size_j;
   logic [EXTENT_BITS-1:0] size_k;
   logic [EXTENT_BITS-1:0] size_l;
   logic                   beyond_end;

   modport source (output valid, output offset_i, output offset_j, output offset_k,
                   output offset_l, output size_i, output size_j, output size_k,
                   output size_l, output beyond_end, input ready);
   modport sink (input valid, input offset_i, input offset_j, input offset_k,
                 input offset_l, input size_i, input size_j, input size_k,
                 input size_l, input beyond_end, output ready);
endinterface

### rtl/tidc_div.sv
// Pipelined restoring divider: one quotient bit per stage, divisor held static.
module tidc_div #(
   parameter int NUM_BITS  = 31,
   parameter int DEN_BITS  = 32,
   parameter int SIDE_BITS = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [NUM_BITS-1:0]  in_num,
   input  logic [SIDE_BITS-1:0] in_side,
   input  logic [DEN_BITS-1:0]  den,
   output logic                 out_valid,
   output logic [NUM_BITS-1:0]  out_quo,
   output logic [DEN_BITS-1:0]  out_rem,
   output logic [SIDE_BITS-1:0] out_side
);

   logic                 v_ff    [NUM_BITS];
   logic [NUM_BITS-1:0]  w_ff    [NUM_BITS];
   logic [DEN_BITS-1:0]  r_ff    [NUM_BITS];
   logic [SIDE_BITS-1:0] side_ff [NUM_BITS];

   genvar s;
   generate
      for (s = 0; s < NUM_BITS; s++) begin : g_stage
         logic                 v_pre;
         logic [NUM_BITS-1:0]  w_pre;
         logic [DEN_BITS-1:0]  r_pre;
         logic [SIDE_BITS-1:0] side_pre;
         logic [DEN_BITS:0]    trial;
         logic [DEN_BITS:0]    diff;
         logic                 ge;
         logic [NUM_BITS-1:0]  w_in;
         logic [DEN_BITS-1:0]  r_in;

         if (s == 0) begin : g_first
            assign v_pre    = in_valid;
            assign w_pre    = in_num;
            assign r_pre    = '0;
            assign side_pre = in_side;
         end else begin : g_next
            assign v_pre    = v_ff[s-1];
            assign w_pre    = w_ff[s-1];
            assign r_pre    = r_ff[s-1];
            assign side_pre = side_ff[s-1];
         end

         // The dividend shifts out at the top while quotient bits shift in below.
         assign trial = {r_pre, w_pre[NUM_BITS-1]};
         assign diff  = trial - {1'b0, den};
         assign ge    = (trial >= {1'b0, den});
         assign r_in  = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         assign w_in  = {w_pre[NUM_BITS-2:0], ge};

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[s] <= 1'b0;
            end else if (en) begin
               v_ff[s] <= v_pre;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               w_ff[s]    <= w_in;
               r_ff[s]    <= r_in;
               side_ff[s] <= side_pre;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[NUM_BITS-1];
   assign out_quo   = w_ff[NUM_BITS-1];
   assign out_rem   = r_ff[NUM_BITS-1];
   assign out_side  = side_ff[NUM_BITS-1];

endmodule

### rtl/tile_index_decompose_4d_core.sv
// Depth: two chained bit-per-stage divider levels, then offset multiply and output registers.
// Throughput: one beat per cycle while the skid slot is empty and no recount is running.
// A two-entry output stage lets one more beat in while a result waits downstream.
// Any register write recomputes the tile counts (LOAD, DIV, CEIL, MUL_*), no input meanwhile.
// Reset (synchronous, active high) sets all extents and steps to 1 and empties the pipe.
`include "tile_index_decompose_4d_core_macros.svh"

module tile_index_decompose_4d_core #(
   parameter int EXTENT_BITS = 16,
   parameter int INDEX_BITS  = 31
) (
   input  logic                                    clock,
   input  logic                                    reset,
   tidc_req_if.sink                                req_chan,
   tidc_rsp_if.source                              rsp_chan,
   input  logic                                    csr_we,
   input  logic [tidc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [EXTENT_BITS-1:0]                  csr_wdata
);

   localparam int PROD_BITS = INDEX_BITS + EXTENT_BITS;
   localparam int BIT_W     = $clog2(EXTENT_BITS);
   localparam int ND        = tidc_pkg::NUM_DIMS;

   localparam logic [2:0] SEQ_IDLE   = 3'd0;
   localparam logic [2:0] SEQ_LOAD   = 3'd1;
   localparam logic [2:0] SEQ_DIV    = 3'd2;
   localparam logic [2:0] SEQ_CEIL   = 3'd3;
   localparam logic [2:0] SEQ_MUL_KL = 3'd4;
   localparam logic [2:0] SEQ_MUL_J  = 3'd5;
   localparam logic [2:0] SEQ_MUL_I  = 3'd6;

   // ---------------- configuration and tile counts ----------------
   logic [EXTENT_BITS-1:0] ext_ff  [ND];
   logic [EXTENT_BITS-1:0] step_ff [ND];
   logic [EXTENT_BITS-1:0] eff_step [ND];
   logic [EXTENT_BITS-1:0] dv_ff   [ND];
   logic [EXTENT_BITS-1:0] rm_ff   [ND];
   logic [EXTENT_BITS-1:0] dv_in   [ND];
   logic [EXTENT_BITS-1:0] rm_in   [ND];
   logic [EXTENT_BITS-1:0] ceil_ff [ND];
   logic [2:0]             seq_ff;
   logic [BIT_W-1:0]       bit_ff;
   tidc_pkg::count_type    kl_ff;
   tidc_pkg::count_type    total_ff;
   logic                   busy;

   always_comb begin
      for (int d = 0; d < ND; d++) begin
         logic [EXTENT_BITS:0] trial;
         logic [EXTENT_BITS:0] diff;
         logic                 ge;
         eff_step[d] = (step_ff[d] == '0) ? EXTENT_BITS'(1) : step_ff[d];
         trial = {rm_ff[d], dv_ff[d][EXTENT_BITS-1]};
         diff  = trial - {1'b0, eff_step[d]};
         ge    = (trial >= {1'b0, eff_step[d]});
         rm_in[d] = ge ? diff[EXTENT_BITS-1:0] : trial[EXTENT_BITS-1:0];
         dv_in[d] = {dv_ff[d][EXTENT_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= SEQ_IDLE;
         kl_ff    <= tidc_pkg::count_type'(1);
         total_ff <= tidc_pkg::count_type'(1);
         for (int d = 0; d < ND; d++) begin
            ext_ff[d]  <= EXTENT_BITS'(1);
            step_ff[d] <= EXTENT_BITS'(1);
            ceil_ff[d] <= EXTENT_BITS'(1);
         end
      end else if (csr_we) begin
         seq_ff <= SEQ_LOAD;
         case (csr_index)
            tidc_pkg::REG_EXTENT_I: ext_ff[tidc_pkg::DIM_I] <= csr_wdata;
            tidc_pkg::REG_EXTENT_J: ext_ff[tidc_pkg::DIM_J] <= csr_wdata;
            tidc_pkg::REG_EXTENT_K: ext_ff[tidc_pkg::DIM_K] <= csr_wdata;
            tidc_pkg::REG_EXTENT_L: ext_ff[tidc_pkg::DIM_L] <= csr_wdata;
            tidc_pkg::REG_STEP_I:   step_ff[tidc_pkg::DIM_I] <= csr_wdata;
            tidc_pkg::REG_STEP_J:   step_ff[tidc_pkg::DIM_J] <= csr_wdata;
            tidc_pkg::REG_STEP_K:   step_ff[tidc_pkg::DIM_K] <= csr_wdata;
            tidc_pkg::REG_STEP_L:   step_ff[tidc_pkg::DIM_L] <= csr_wdata;
            default: ;
         endcase
      end else begin
         case (seq_ff)
            SEQ_LOAD: begin
               bit_ff <= BIT_W'(EXTENT_BITS - 1);
               seq_ff <= SEQ_DIV;
            end
            SEQ_DIV: begin
               bit_ff <= bit_ff - BIT_W'(1);
               if (bit_ff == '0) begin
                  seq_ff <= SEQ_CEIL;
               end
            end
            SEQ_CEIL: begin
               for (int d = 0; d < ND; d++) begin
                  ceil_ff[d] <= dv_ff[d] + EXTENT_BITS'(rm_ff[d] != '0);
               end
               seq_ff <= SEQ_MUL_KL;
            end
            SEQ_MUL_KL: begin
               kl_ff  <= tidc_pkg::sat_count(
                            64'(ceil_ff[tidc_pkg::DIM_K]) * 64'(ceil_ff[tidc_pkg::DIM_L]));
               seq_ff <= SEQ_MUL_J;
            end
            SEQ_MUL_J: begin
               total_ff <= tidc_pkg::sat_count(64'(kl_ff) * 64'(ceil_ff[tidc_pkg::DIM_J]));
               seq_ff   <= SEQ_MUL_I;
            end
            SEQ_MUL_I: begin
               total_ff <= tidc_pkg::sat_count(
                              64'(total_ff) * 64'(ceil_ff[tidc_pkg::DIM_I]));
               seq_ff   <= SEQ_IDLE;
            end
            default: seq_ff <= SEQ_IDLE;
         endcase
      end
   end

   // The serial ceiling dividers shift one bit per cycle for all four dimensions at once.
   always_ff @(posedge clock) begin
      for (int d = 0; d < ND; d++) begin
         if (seq_ff == SEQ_LOAD) begin
            dv_ff[d] <= ext_ff[d];
            rm_ff[d] <= '0;
         end else if (seq_ff == SEQ_DIV) begin
            dv_ff[d] <= dv_in[d];
            rm_ff[d] <= rm_in[d];
         end
      end
   end

   assign busy = (seq_ff != SEQ_IDLE);

   // ---------------- tile number pipeline ----------------
   logic                   adv;
   logic                   skid_v_ff;
   logic                   in_beyond;

   logic                   a_valid;
   logic [INDEX_BITS-1:0]  a_quo;
   tidc_pkg::count_type    a_rem;
   logic                   a_beyond;

   logic                   b_valid;
   logic [INDEX_BITS-1:0]  b_quo;
   logic [EXTENT_BITS-1:0] b_rem;
   logic                   b_beyond;
   logic                   c_valid;
   logic [INDEX_BITS-1:0]  c_quo;
   logic [EXTENT_BITS-1:0] c_rem;
   logic                   c_beyond;

   // A stage only moves while the skid slot is empty.
   assign adv            = !skid_v_ff;
   assign req_chan.ready = adv && !busy;
   assign in_beyond      = (tidc_pkg::COUNT_BITS'(req_chan.tile_number) >= total_ff);

   tidc_div #(
      .NUM_BITS  (INDEX_BITS),
      .DEN_BITS  (tidc_pkg::COUNT_BITS),
      .SIDE_BITS (1)
   ) u_div_kl (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_chan.valid && req_chan.ready),
      .in_num    (req_chan.tile_number),
      .in_side   (in_beyond),
      .den       (kl_ff),
      .out_valid (a_valid),
      .out_quo   (a_quo),
      .out_rem   (a_rem),
      .out_side  (a_beyond)
   );

   tidc_div #(
      .NUM_BITS  (INDEX_BITS),
      .DEN_BITS  (EXTENT_BITS),
      .SIDE_BITS (1)
   ) u_div_j (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (a_valid),
      .in_num    (a_quo),
      .in_side   (a_beyond),
      .den       (ceil_ff[tidc_pkg::DIM_J]),
      .out_valid (b_valid),
      .out_quo   (b_quo),
      .out_rem   (b_rem),
      .out_side  (b_beyond)
   );

   // The remainder is no larger than the tile number, so it fits the index width.
   tidc_div #(
      .NUM_BITS  (INDEX_BITS),
      .DEN_BITS  (EXTENT_BITS),
      .SIDE_BITS (1)
   ) u_div_l (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (a_valid),
      .in_num    (a_rem[INDEX_BITS-1:0]),
      .in_side   (a_beyond),
      .den       (ceil_ff[tidc_pkg::DIM_L]),
      .out_valid (c_valid),
      .out_quo   (c_quo),
      .out_rem   (c_rem),
      .out_side  (c_beyond)
   );

   // Offset multiply stage.
   logic [INDEX_BITS-1:0]  tile_idx [ND];
   logic                   p1_v_ff;
   logic                   p1_beyond_ff;
   logic [PROD_BITS-1:0]   p1_off_ff [ND];

   assign tile_idx[tidc_pkg::DIM_I] = b_quo;
   assign tile_idx[tidc_pkg::DIM_J] = INDEX_BITS'(b_rem);
   assign tile_idx[tidc_pkg::DIM_K] = c_quo;
   assign tile_idx[tidc_pkg::DIM_L] = INDEX_BITS'(c_rem);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= b_valid && c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_beyond_ff <= b_beyond || c_beyond;
         for (int d = 0; d < ND; d++) begin
            p1_off_ff[d] <= PROD_BITS'(tile_idx[d]) * PROD_BITS'(eff_step[d]);
         end
      end
   end

   // Clamp at the extent edge; a tile past the end reads all zero.
   logic [EXTENT_BITS-1:0] cl_off  [ND];
   logic [EXTENT_BITS-1:0] cl_size [ND];

   always_comb begin
      for (int d = 0; d < ND; d++) begin
         logic [EXTENT_BITS-1:0] rest;
         if (PROD_BITS'(ext_ff[d]) > p1_off_ff[d]) begin
            rest = ext_ff[d] - p1_off_ff[d][EXTENT_BITS-1:0];
         end else begin
            rest = '0;
         end
         if (p1_beyond_ff) begin
            cl_off[d]  = '0;
            cl_size[d] = '0;
         end else begin
            cl_off[d]  = p1_off_ff[d][EXTENT_BITS-1:0];
            cl_size[d] = (eff_step[d] < rest) ? eff_step[d] : rest;
         end
      end
   end

   // Output register with one skid slot behind it.
   logic                   fire;
   logic                   rsp_v_ff;
   logic                   rsp_beyond_ff;
   logic [EXTENT_BITS-1:0] rsp_off_ff  [ND];
   logic [EXTENT_BITS-1:0] rsp_size_ff [ND];
   logic                   skid_beyond_ff;
   logic [EXTENT_BITS-1:0] skid_off_ff  [ND];
   logic [EXTENT_BITS-1:0] skid_size_ff [ND];

   assign fire = p1_v_ff && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!rsp_v_ff || rsp_chan.ready) begin
         if (skid_v_ff) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            rsp_v_ff <= fire;
         end
      end else if (fire) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_v_ff || rsp_chan.ready) begin
         if (skid_v_ff) begin
            rsp_beyond_ff <= skid_beyond_ff;
            rsp_off_ff    <= skid_off_ff;
            rsp_size_ff   <= skid_size_ff;
         end else begin
            rsp_beyond_ff <= p1_beyond_ff;
            rsp_off_ff    <= cl_off;
            rsp_size_ff   <= cl_size;
         end
      end else if (fire) begin
         skid_beyond_ff <= p1_beyond_ff;
         skid_off_ff    <= cl_off;
         skid_size_ff   <= cl_size;
      end
   end

   assign rsp_chan.valid      = rsp_v_ff;
   assign rsp_chan.beyond_end = rsp_beyond_ff;
   assign rsp_chan.offset_i   = rsp_off_ff[tidc_pkg::DIM_I];
   assign rsp_chan.offset_j   = rsp_off_ff[tidc_pkg::DIM_J];
   assign rsp_chan.offset_k   = rsp_off_ff[tidc_pkg::DIM_K];
   assign rsp_chan.offset_l   = rsp_off_ff[tidc_pkg::DIM_L];
   assign rsp_chan.size_i     = rsp_size_ff[tidc_pkg::DIM_I];
   assign rsp_chan.size_j     = rsp_size_ff[tidc_pkg::DIM_J];
   assign rsp_chan.size_k     = rsp_size_ff[tidc_pkg::DIM_K];
   assign rsp_chan.size_l     = rsp_size_ff[tidc_pkg::DIM_L];

   // ---------------- checks ----------------
   `TIDC_ASSERT_NEXT(a_cfg_restarts_counts, clock, reset, csr_we, seq_ff != SEQ_IDLE)
   `TIDC_ASSERT_IMPL(a_split_lanes_lockstep, clock, reset, 1'b1, b_valid == c_valid)
   `TIDC_ASSERT_IMPL(a_skid_behind_output, clock, reset, skid_v_ff, rsp_v_ff)
   `TIDC_ASSERT_IMPL(a_beyond_reads_zero, clock, reset, rsp_v_ff && rsp_beyond_ff, rsp_chan.size_i == '0 && rsp_chan.size_l == '0 && rsp_chan.offset_j == '0)

endmodule
